// ===== sv/kmp_pkg.sv =====
package kmp_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int TOKEN_BITS  = 32;

	localparam int TOK_W   = 32;
	localparam int CMP_W   = (TOKEN_BITS < TOK_W) ? TOKEN_BITS : TOK_W;
	localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int COUNT_W = 32;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_TEXT    = 2'd1,
		OP_RESTART = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// read bus handed from cell to cell
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] fb;
	} link_t;

	// write controls broadcast to every cell
	typedef struct packed {
		logic             tok_we;
		logic [IDX_W-1:0] tok_idx;
		logic [CMP_W-1:0] tok;
		logic             fb_we;
		logic [IDX_W-1:0] fb_idx;
		logic [IDX_W-1:0] fb;
	} cell_wr_t;

endpackage

// ===== sv/kmp_in_if.sv =====
interface kmp_in_if
	import kmp_pkg::*;
();
	logic              valid;
	logic              ready;
	opcode_t           opcode;
	logic [TOK_W-1:0]  token;

	modport source (output valid, output opcode, output token, input ready);
	modport sink   (input valid, input opcode, input token, output ready);
endinterface

// ===== sv/kmp_out_if.sv =====
interface kmp_out_if
	import kmp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [COUNT_W-1:0] match_count;
	status_t            status;

	modport source (output valid, output match_found, output match_count, output status,
		input ready);
	modport sink   (input valid, input match_found, input match_count, input status,
		output ready);
endinterface

// ===== sv/kmp_cell.sv =====
module kmp_cell
	import kmp_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] pos,
	input  cell_wr_t         wr,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic [CMP_W-1:0] key,
	input  link_t            link_in,
	output link_t            link_out
);

	// pattern token at this position and fallback entry of the position before
	logic [CMP_W-1:0] tok_q;
	logic [IDX_W-1:0] fb_q;

	always_ff @(posedge clk) begin
		if (wr.tok_we && wr.tok_idx == pos) begin
			tok_q <= wr.tok;
		end
		if (wr.fb_we && wr.fb_idx == pos) begin
			fb_q <= wr.fb;
		end
	end

	always_comb begin
		if (rd_idx == pos) begin
			link_out.hit = (tok_q == key);
			link_out.fb  = fb_q;
		end else begin
			link_out = link_in;
		end
	end

endmodule

// ===== sv/kmp_token_stream_matcher.sv =====
// token stream matcher with a row of pattern cells
// items channel carries opcode and token: load pattern token, text token,
// restart search, clear pattern; results channel returns one transaction
// per item with match_found, match_count and status
// an item is taken and worked on in the cycle after; each fallback step
// of the walk through the pattern cells loads a new cell index into k_q,
// and the result is registered when the walk ends; over a long text the
// fallback steps average at most one per text token
// the next item can be taken in the cycle in which the result is accepted
// one item is in flight at a time; a stalled receiver holds the result and
// the block takes no further item until that result is gone
// reset clears pattern length, prefix length, match position and count;
// pattern cells are written by loads and are not cleared
module kmp_token_stream_matcher
	import kmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	kmp_in_if.sink     items,
	kmp_out_if.source  results
);

	state_t             state_q, state_d;
	opcode_t            op_q;
	logic [CMP_W-1:0]   tok_q;
	logic [IDX_W-1:0]   k_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   prefix_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   last_fb_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [COUNT_W-1:0] out_count_q;
	status_t            out_status_q;

	link_t              links [MAX_PATTERN+1];
	cell_wr_t           wr;

	logic               accept;
	logic               hit;
	logic               need_walk;
	logic               step_back;
	logic               finish;
	logic               is_load;
	logic               is_text;
	logic [IDX_W-1:0]   k_start;
	logic [IDX_W-1:0]   k_load;
	logic [LEN_W-1:0]   j_next;
	logic               full_match;

	assign accept        = items.valid && items.ready;
	assign items.ready   = (state_q == ST_IDLE) && (!out_valid_q || results.ready);

	assign results.valid       = out_valid_q;
	assign results.match_found = out_found_q;
	assign results.match_count = out_count_q;
	assign results.status      = out_status_q;

	assign links[0] = '0;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		kmp_cell u_cell (
			.clk      (clk),
			.pos      (IDX_W'(i)),
			.wr       (wr),
			.rd_idx   (k_q),
			.key      (tok_q),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign hit = links[MAX_PATTERN].hit;

	always_comb begin
		if (items.opcode == OP_LOAD) begin
			k_start = prefix_q;
		end else if (LEN_W'(pos_q) >= len_q) begin
			k_start = '0;
		end else begin
			k_start = pos_q;
		end
	end

	assign is_load   = (op_q == OP_LOAD) && (len_q < LEN_W'(MAX_PATTERN));
	assign is_text   = (op_q == OP_TEXT) && (len_q != '0);
	assign need_walk = is_load || is_text;
	assign step_back = need_walk && (k_q != '0) && !hit;
	assign finish    = (state_q == ST_EXEC) && !step_back;

	assign k_load     = (hit && (LEN_W'(k_q) < len_q)) ? k_q + 1'b1 : k_q;
	assign j_next     = LEN_W'(k_q) + LEN_W'(hit);
	assign full_match = (j_next >= len_q);

	always_comb begin
		wr         = '0;
		wr.tok     = tok_q;
		wr.tok_idx = len_q[IDX_W-1:0];
		wr.fb      = k_load;
		wr.fb_idx  = IDX_W'(len_q + 1'b1);
		if (finish && is_load) begin
			wr.tok_we = 1'b1;
			wr.fb_we  = (len_q != LEN_W'(MAX_PATTERN - 1));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= items.opcode;
			tok_q <= items.token[CMP_W-1:0];
			k_q   <= k_start;
		end else if (state_q == ST_EXEC && step_back) begin
			k_q <= links[MAX_PATTERN].fb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			prefix_q    <= '0;
			pos_q       <= '0;
			last_fb_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				case (op_q)
					OP_LOAD: begin
						if (is_load) begin
							prefix_q  <= k_load;
							last_fb_q <= k_load;
							len_q     <= len_q + 1'b1;
							pos_q     <= '0;
							count_q   <= '0;
						end
					end
					OP_TEXT: begin
						if (is_text) begin
							if (full_match) begin
								pos_q <= last_fb_q;
								if (count_q != '1) begin
									count_q <= count_q + 1'b1;
								end
							end else begin
								pos_q <= j_next[IDX_W-1:0];
							end
						end
					end
					OP_CLEAR: begin
						pos_q    <= '0;
						count_q  <= '0;
						len_q    <= '0;
						prefix_q <= '0;
					end
					default: begin
						pos_q   <= '0;
						count_q <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_found_q  <= 1'b0;
			out_count_q  <= count_q;
			out_status_q <= STAT_OK;
			case (op_q)
				OP_LOAD: begin
					if (is_load) begin
						out_count_q <= '0;
					end else begin
						out_status_q <= STAT_FULL;
					end
				end
				OP_TEXT: begin
					if (!is_text) begin
						out_status_q <= STAT_EMPTY;
					end else if (full_match) begin
						out_found_q <= 1'b1;
						if (count_q != '1) begin
							out_count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					out_count_q <= '0;
				end
			endcase
		end
	end

	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> !out_valid_q)
		else $error("result register busy while an item is in work");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted transaction not taken into work");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PATTERN))
		else $error("pattern length beyond cell count");

	a_pos_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_q != '0 |-> (LEN_W'(pos_q) < len_q) && (LEN_W'(prefix_q) < len_q))
		else $error("match position or prefix length not below pattern length");

endmodule

// ===== tb/kmp_match_checker.sv =====
module kmp_match_checker
	import kmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kmp_in_if           items,
	kmp_out_if          results,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               match_found;
		logic [COUNT_W-1:0] match_count;
		status_t            status;
	} match_result_t;

	match_result_t    pending_results[$];
	match_result_t    want;
	logic [CMP_W-1:0] pattern_tokens[MAX_PATTERN];
	int unsigned      fallback_links[MAX_PATTERN];
	int unsigned      pattern_len;
	int unsigned      prefix_len;
	int unsigned      match_pos;
	logic [COUNT_W-1:0] occurrences;

	// advance the matcher state by one transaction and return its result
	function automatic match_result_t match_step(opcode_t op, logic [TOK_W-1:0] token);
		match_result_t    res;
		logic [CMP_W-1:0] tok;
		int unsigned      k;
		res.match_found = 1'b0;
		res.status      = STAT_OK;
		tok             = token[CMP_W-1:0];
		case (op)
			OP_LOAD: begin
				if (pattern_len >= MAX_PATTERN) begin
					res.status = STAT_FULL;
				end else begin
					pattern_tokens[pattern_len] = tok;
					if (pattern_len == 0) begin
						prefix_len        = 0;
						fallback_links[0] = 0;
					end else begin
						k = prefix_len;
						while (k > 0 && pattern_tokens[k] != tok)
							k = fallback_links[k-1];
						if (pattern_tokens[k] == tok && k < pattern_len)
							k++;
						prefix_len                  = k;
						fallback_links[pattern_len] = k;
					end
					pattern_len++;
					match_pos   = 0;
					occurrences = '0;
				end
			end
			OP_TEXT: begin
				if (pattern_len == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					k = (match_pos >= pattern_len) ? 0 : match_pos;
					while (k > 0 && pattern_tokens[k] != tok)
						k = fallback_links[k-1];
					if (pattern_tokens[k] == tok)
						k++;
					if (k >= pattern_len) begin
						res.match_found = 1'b1;
						if (occurrences != '1)
							occurrences++;
						k = fallback_links[pattern_len-1];
					end
					match_pos = k;
				end
			end
			default: begin
				match_pos   = 0;
				occurrences = '0;
				if (op == OP_CLEAR) begin
					pattern_len = 0;
					prefix_len  = 0;
				end
			end
		endcase
		res.match_count = occurrences;
		return res;
	endfunction

	function automatic void flag_mismatch(string what, logic [COUNT_W-1:0] exp_val,
		logic [COUNT_W-1:0] act_val);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
				act_val);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			pattern_len = 0;
			prefix_len  = 0;
			match_pos   = 0;
			occurrences = '0;
			fail_count  = 0;
			outstanding = 0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				pattern_tokens[i] = '0;
				fallback_links[i] = 0;
			end
		end else begin
			if (items.valid && items.ready)
				pending_results = {pending_results, match_step(items.opcode, items.token)};
			if (results.valid && results.ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unrequested transaction", '0, results.match_count);
				end else begin
					want = pending_results.pop_front();
					if (results.match_found !== want.match_found)
						flag_mismatch("match_found", COUNT_W'(want.match_found),
							COUNT_W'(results.match_found));
					if (results.match_count !== want.match_count)
						flag_mismatch("match_count", want.match_count, results.match_count);
					if (results.status !== want.status)
						flag_mismatch("status", COUNT_W'(want.status),
							COUNT_W'(results.status));
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/tb_kmp_token_stream_matcher.sv =====
module tb_kmp_token_stream_matcher
	import kmp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TOK_W-1:0] ALL_ONES = '1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        calm;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned loaded_len;
	int unsigned useful_items;

	kmp_in_if  items();
	kmp_out_if results();

	kmp_token_stream_matcher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	kmp_match_checker match_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.results     (results),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		results.ready <= calm || ($urandom_range(99) >= 9);
	end

	// one transaction on the item channel, with random idle cycles ahead of it
	task automatic send_item(opcode_t op, logic [TOK_W-1:0] tok);
		while (!calm && $urandom_range(99) < 9) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid  <= 1'b1;
		items.opcode <= op;
		items.token  <= tok;
		do @(posedge clk); while (!items.ready);
		@(negedge clk);
		case (op)
			OP_LOAD: begin
				if (loaded_len < MAX_PATTERN) begin
					loaded_len++;
					useful_items++;
				end
			end
			OP_TEXT: begin
				if (loaded_len != 0)
					useful_items++;
			end
			OP_CLEAR: begin
				loaded_len = 0;
				useful_items++;
			end
			default: useful_items++;
		endcase
	endtask

	task automatic drain_results();
		items.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic [TOK_W-1:0] alphabet[4];
		logic [TOK_W-1:0] pattern_q[$];
		logic [TOK_W-1:0] tok;
		int unsigned      alpha_n;
		int unsigned      pat_n;
		int unsigned      text_n;
		int unsigned      sent;
		int unsigned      pick;
		int               round;

		arst_n         = 1'b0;
		calm           = 1'b0;
		items.valid    = 1'b0;
		items.opcode   = OP_LOAD;
		items.token    = '0;
		results.ready  = 1'b0;
		loaded_len     = 0;
		useful_items   = 0;
		round          = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pattern, single token pattern, overlapping matches, load resets search
		send_item(OP_TEXT, '0);
		send_item(OP_RESTART, ALL_ONES);
		send_item(OP_CLEAR, '0);
		send_item(OP_LOAD, ALL_ONES);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_TEXT, '0);
		send_item(OP_CLEAR, ALL_ONES);
		send_item(OP_LOAD, ALL_ONES);
		send_item(OP_LOAD, '0);
		send_item(OP_LOAD, ALL_ONES);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_TEXT, '0);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_TEXT, '0);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_RESTART, '0);
		send_item(OP_TEXT, ALL_ONES);
		send_item(OP_LOAD, '0);
		send_item(OP_TEXT, 32'h5555_aaaa);
		send_item(OP_CLEAR, 32'haaaa_5555);
		send_item(OP_TEXT, 32'h1);
		drain_results();

		while (useful_items < 1450) begin
			round++;
			calm = (round >= 30 && round < 55);
			if (round == 20 || round == 70)
				drain_results();
			pick = $urandom_range(99);
			if (pick < 85) begin
				// pattern over a small alphabet, then text built to hit it
				alpha_n = $urandom_range(2, 4);
				for (int i = 0; i < 4; i++)
					alphabet[i] = $urandom;
				if ($urandom_range(9) == 0)
					alphabet[0] = ($urandom_range(1) != 0) ? ALL_ONES : '0;
				if ($urandom_range(3) == 0)
					alphabet[1] = alphabet[0] ^ (32'h1 << $urandom_range(31));
				pick  = $urandom_range(99);
				pat_n = (pick < 70) ? $urandom_range(1, 5) :
					(pick < 92) ? $urandom_range(6, MAX_PATTERN) :
					$urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 2);
				if ($urandom_range(4) != 0)
					send_item(OP_CLEAR, $urandom);
				pattern_q.delete();
				for (int i = 0; i < pat_n; i++) begin
					tok = alphabet[$urandom_range(alpha_n - 1)];
					pattern_q = {pattern_q, tok};
					send_item(OP_LOAD, tok);
				end
				text_n = $urandom_range(10, 40);
				sent   = 0;
				while (sent < text_n) begin
					pick = $urandom_range(99);
					if (pick < 35) begin
						foreach (pattern_q[i])
							send_item(OP_TEXT, pattern_q[i]);
						sent += pattern_q.size();
					end else begin
						if (pick < 40)
							send_item(OP_RESTART, $urandom);
						else if (pick < 45)
							send_item(OP_TEXT, alphabet[$urandom_range(alpha_n - 1)] ^
								(32'h1 << $urandom_range(31)));
						else
							send_item(OP_TEXT, alphabet[$urandom_range(alpha_n - 1)]);
						sent++;
					end
				end
			end else begin
				repeat ($urandom_range(5, 15))
					send_item(opcode_t'($urandom_range(3)), $urandom);
			end
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

endmodule
